// ===== design/esc_pkg.sv =====
package esc_pkg;

    localparam int unsigned REQ_W   = 8;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned IDX_W   = 2;

    localparam logic signed [REQ_W-1:0] DRIVE_MAX = 8'sd100;
    localparam logic signed [REQ_W-1:0] DRIVE_MIN = -8'sd100;

    localparam logic [CFG_W-1:0] BRAKE_TIME_RST = 16'd250;
    localparam logic [CFG_W-1:0] PAUSE_TIME_RST = 16'd100;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_BRAKE_TIME = 2'd0;
    localparam logic [IDX_W-1:0] CFG_PAUSE_TIME = 2'd1;

    typedef enum logic [PHASE_W-1:0] {
        PH_NEUTRAL = 3'd0,
        PH_FORWARD = 3'd1,
        PH_BRAKING = 3'd2,
        PH_PAUSE   = 3'd3,
        PH_REVERSE = 3'd4
    } t_phase;

    typedef struct packed {
        logic signed [REQ_W-1:0] request;
        logic [TIME_W-1:0]       time_now;
    } t_step_in;

    typedef struct packed {
        logic signed [REQ_W-1:0] drive_out;
        t_phase                  phase;
    } t_step_out;

    typedef struct packed {
        logic [CFG_W-1:0] brake_time_ms;
        logic [CFG_W-1:0] pause_time_ms;
    } t_cfg;

endpackage

// ===== design/esc_brake_reverse_sequencer.sv =====
// Brake-then-reverse drive sequencer.
// A word goes from the input register to the result register, which drives the outputs.
// Throughput: one word per cycle while the output is not stalled; the step logic between
// the input and result registers (one 32-bit subtract and two compares) sets the cycle.
// Reset (synchronous, active low): neutral phase, zero drive, timers 250 and 100 ms.
module esc_brake_reverse_sequencer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic signed [esc_pkg::REQ_W-1:0] i_request,
    input  logic [esc_pkg::TIME_W-1:0]       i_time_now,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [esc_pkg::REQ_W-1:0] o_drive_out,
    output logic [esc_pkg::PHASE_W-1:0]      o_phase,
    input  logic                             i_cfg_we,
    input  logic [esc_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [esc_pkg::CFG_W-1:0]        i_cfg_data
);

    esc_pkg::t_cfg      r_cfg;
    logic               r_in_valid;
    esc_pkg::t_step_in  r_in;
    logic               r_out_valid;
    esc_pkg::t_step_out r_out;
    esc_pkg::t_step_out step_result;
    logic               advance;
    logic               in_accept;

    // move the held word on when the result register is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brake_time_ms <= esc_pkg::BRAKE_TIME_RST;
            r_cfg.pause_time_ms <= esc_pkg::PAUSE_TIME_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                esc_pkg::CFG_BRAKE_TIME: r_cfg.brake_time_ms <= i_cfg_data;
                esc_pkg::CFG_PAUSE_TIME: r_cfg.pause_time_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.request  <= i_request;
            r_in.time_now <= i_time_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    esc_seq_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (step_result)
    );

    assign o_out_valid = r_out_valid;
    assign o_drive_out = r_out.drive_out;
    assign o_phase     = r_out.phase;

endmodule

// ===== design/esc_seq_core.sv =====
module esc_seq_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  esc_pkg::t_step_in  i_item,
    input  esc_pkg::t_cfg      i_cfg,
    output esc_pkg::t_step_out o_result
);

    esc_pkg::t_phase                         r_mode;
    esc_pkg::t_phase                         n_mode;
    logic [esc_pkg::TIME_W-1:0]              r_entry_time;
    logic [esc_pkg::TIME_W-1:0]              n_entry_time;
    logic signed [esc_pkg::REQ_W-1:0]        r_last_drive;
    logic signed [esc_pkg::REQ_W-1:0]        n_last_drive;

    logic signed [esc_pkg::REQ_W-1:0]        req;
    logic [esc_pkg::TIME_W-1:0]              elapsed;
    logic                                    brake_done;
    logic                                    pause_done;
    esc_pkg::t_phase                         leave_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= esc_pkg::PH_NEUTRAL;
            r_entry_time <= '0;
            r_last_drive <= '0;
        end else if (i_step) begin
            r_mode       <= n_mode;
            r_entry_time <= n_entry_time;
            r_last_drive <= n_last_drive;
        end
    end

    always_comb begin
        if (i_item.request > esc_pkg::DRIVE_MAX) begin
            req = esc_pkg::DRIVE_MAX;
        end else if (i_item.request < esc_pkg::DRIVE_MIN) begin
            req = esc_pkg::DRIVE_MIN;
        end else begin
            req = i_item.request;
        end
    end

    // wrapping difference from the stored entry timestamp
    assign elapsed    = i_item.time_now - r_entry_time;
    assign brake_done = elapsed >= {{(esc_pkg::TIME_W-esc_pkg::CFG_W){1'b0}}, i_cfg.brake_time_ms};
    assign pause_done = elapsed >= {{(esc_pkg::TIME_W-esc_pkg::CFG_W){1'b0}}, i_cfg.pause_time_ms};
    assign leave_mode = (req > 8'sd0) ? esc_pkg::PH_FORWARD : esc_pkg::PH_NEUTRAL;

    always_comb begin
        n_mode       = r_mode;
        n_entry_time = r_entry_time;
        n_last_drive = r_last_drive;
        case (r_mode)
            esc_pkg::PH_NEUTRAL: begin
                if (req > 8'sd0) begin
                    n_mode       = esc_pkg::PH_FORWARD;
                    n_last_drive = req;
                end else if (req < 8'sd0) begin
                    n_mode       = esc_pkg::PH_BRAKING;
                    n_entry_time = i_item.time_now;
                    n_last_drive = req;
                end else begin
                    n_last_drive = '0;
                end
            end
            esc_pkg::PH_FORWARD: begin
                if (req < 8'sd0) begin
                    n_mode       = esc_pkg::PH_BRAKING;
                    n_entry_time = i_item.time_now;
                    n_last_drive = req;
                end else if (req == 8'sd0) begin
                    n_mode       = esc_pkg::PH_NEUTRAL;
                    n_last_drive = '0;
                end else begin
                    n_last_drive = req;
                end
            end
            esc_pkg::PH_BRAKING: begin
                if (req >= 8'sd0) begin
                    n_mode       = leave_mode;
                    n_last_drive = req;
                end else if (brake_done) begin
                    // restart the clock for the zero-output pause
                    n_mode       = esc_pkg::PH_PAUSE;
                    n_entry_time = i_item.time_now;
                    n_last_drive = '0;
                end else begin
                    n_last_drive = req;
                end
            end
            esc_pkg::PH_PAUSE: begin
                if (req >= 8'sd0) begin
                    n_mode       = leave_mode;
                    n_last_drive = req;
                end else if (pause_done) begin
                    n_mode       = esc_pkg::PH_REVERSE;
                    n_last_drive = req;
                end else begin
                    n_last_drive = '0;
                end
            end
            esc_pkg::PH_REVERSE: begin
                if (req >= 8'sd0) begin
                    n_mode = leave_mode;
                end
                n_last_drive = req;
            end
            default: begin
                // unknown code: drop back to the reset state
                n_mode       = esc_pkg::PH_NEUTRAL;
                n_entry_time = '0;
                n_last_drive = '0;
            end
        endcase
    end

    assign o_result.drive_out = n_last_drive;
    assign o_result.phase     = n_mode;

    a_pause_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == esc_pkg::PH_PAUSE |-> r_last_drive == 8'sd0)
        else $error("pause phase with nonzero drive");

    a_neutral_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == esc_pkg::PH_NEUTRAL |-> r_last_drive == 8'sd0)
        else $error("neutral phase with nonzero drive");

    a_reverse_path_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == esc_pkg::PH_BRAKING || r_mode == esc_pkg::PH_REVERSE)
        |-> (r_last_drive < 8'sd0 && r_last_drive >= esc_pkg::DRIVE_MIN))
        else $error("reverse path drive not in negative range");

    a_forward_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == esc_pkg::PH_FORWARD
        |-> (r_last_drive > 8'sd0 && r_last_drive <= esc_pkg::DRIVE_MAX))
        else $error("forward phase drive not in positive range");

    a_pause_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_mode == esc_pkg::PH_BRAKING && n_mode == esc_pkg::PH_PAUSE)
        |=> r_entry_time == $past(i_item.time_now))
        else $error("pause entry timestamp not captured");

endmodule
